### hw/rtl/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge outside reset.
`define UET_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define UET_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/uet_pkg.sv
package uet_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int ECW = 12;

	localparam logic [2:0] MODE_CONNECT    = 3'd0;
	localparam logic [2:0] MODE_DISCONNECT = 3'd1;
	localparam logic [2:0] MODE_QUERY      = 3'd2;
	localparam logic [2:0] MODE_NEIGHBOURS = 3'd3;
	localparam logic [2:0] MODE_VERTICES   = 3'd4;
	localparam logic [2:0] MODE_EDGES_FROM = 3'd5;

	typedef logic [MAX_VERTICES-1:0] row_t;

	typedef enum logic [2:0] {
		OP_CONNECT,
		OP_DISCONNECT,
		OP_QUERY,
		OP_NEIGHBOURS,
		OP_VERTICES,
		OP_EDGES_FROM,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
	} cmd_t;

	typedef struct packed {
		logic           adjacent;
		logic           changed;
		logic [VCW-1:0] vertices_in_use;
		logic [ECW-1:0] edges_in_use;
		logic [VW-1:0]  listed_vertex;
		logic           item_valid;
		logic           last;
	} res_t;

	function automatic op_t classify(logic [2:0] mode);
		op_t op;
		case (mode)
			MODE_CONNECT:    op = OP_CONNECT;
			MODE_DISCONNECT: op = OP_DISCONNECT;
			MODE_QUERY:      op = OP_QUERY;
			MODE_NEIGHBOURS: op = OP_NEIGHBOURS;
			MODE_VERTICES:   op = OP_VERTICES;
			MODE_EDGES_FROM: op = OP_EDGES_FROM;
			default:         op = OP_NONE;
		endcase
		return op;
	endfunction

	// index of the lowest set bit; 0 for an all-zero row
	function automatic logic [VW-1:0] lsb_index(row_t x);
		row_t          iso;
		logic [VW-1:0] idx;
		iso = x & (~x + row_t'(1));
		idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (iso[i]) begin
				idx = idx | VW'(i);
			end
		end
		return idx;
	endfunction

endpackage

### hw/rtl/uet_front.sv
module uet_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [2:0]              mode,
	input  logic [uet_pkg::VW-1:0]  vertex_a,
	input  logic [uet_pkg::VW-1:0]  vertex_b,
	input  logic                    push,
	output logic                    full,
	output uet_pkg::cmd_t           cmd,
	output logic                    cmd_valid,
	input  logic                    cmd_take
);

	uet_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= '{op: uet_pkg::classify(mode), a: vertex_a, b: vertex_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, cmd_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/uet_back.sv
module uet_back (
	input  logic          clk,
	input  logic          arst_n,
	input  uet_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  logic          res_full,
	output logic          res_push,
	output uet_pkg::res_t res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_WR_A,
		S_WR_B,
		S_EMIT,
		S_LIST
	} state_t;

	state_t                      state_q;
	uet_pkg::cmd_t               cmd_q;
	uet_pkg::row_t               row_mem [uet_pkg::MAX_VERTICES];
	uet_pkg::row_t               rd_a_q;
	uet_pkg::row_t               rd_b_q;
	uet_pkg::row_t               wr_a_q;
	uet_pkg::row_t               wr_b_q;
	uet_pkg::row_t               nz_q;
	uet_pkg::row_t               scan_q;
	logic                        adj_q;
	logic                        chg_q;
	logic [uet_pkg::VCW-1:0]     vert_q;
	logic [uet_pkg::ECW-1:0]     edge_q;

	uet_pkg::row_t               row_a;
	uet_pkg::row_t               row_b;
	uet_pkg::row_t               bit_a;
	uet_pkg::row_t               bit_b;
	uet_pkg::row_t               set_a;
	uet_pkg::row_t               set_b;
	uet_pkg::row_t               clr_a;
	uet_pkg::row_t               clr_b;
	uet_pkg::row_t               rest;
	logic                        has;
	logic                        distinct;
	logic [1:0]                  inc;
	logic [1:0]                  dec;
	logic [uet_pkg::VW-1:0]      lowest;

	// a row whose nonzero flag is clear reads as empty, stale data or not
	assign row_a    = nz_q[cmd_q.a] ? rd_a_q : '0;
	assign row_b    = nz_q[cmd_q.b] ? rd_b_q : '0;
	assign bit_a    = uet_pkg::row_t'(1) << cmd_q.a;
	assign bit_b    = uet_pkg::row_t'(1) << cmd_q.b;
	assign has      = row_a[cmd_q.b];
	assign distinct = (cmd_q.a != cmd_q.b);
	assign set_a    = row_a | bit_b;
	assign set_b    = row_b | bit_a;
	assign clr_a    = row_a & ~bit_b;
	assign clr_b    = row_b & ~bit_a;
	assign inc      = {1'b0, row_a == '0} + {1'b0, distinct && (row_b == '0)};
	assign dec      = {1'b0, clr_a == '0} + {1'b0, distinct && (clr_b == '0)};
	assign rest     = scan_q & (scan_q - uet_pkg::row_t'(1));
	assign lowest   = uet_pkg::lsb_index(scan_q);

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;
	assign res_push = ((state_q == S_EMIT) || (state_q == S_LIST)) && !res_full;

	always_comb begin
		res.vertices_in_use = vert_q;
		res.edges_in_use    = edge_q;
		if (state_q == S_LIST) begin
			res.adjacent      = 1'b0;
			res.changed       = 1'b0;
			res.listed_vertex = lowest;
			res.item_valid    = (scan_q != '0);
			res.last          = (rest == '0);
		end else begin
			res.adjacent      = adj_q;
			res.changed       = chg_q;
			res.listed_vertex = '0;
			res.item_valid    = 1'b0;
			res.last          = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			rd_a_q <= row_mem[cmd.a];
			rd_b_q <= row_mem[cmd.b];
		end
		if (state_q == S_WR_A) begin
			row_mem[cmd_q.a] <= wr_a_q;
		end else if (state_q == S_WR_B) begin
			row_mem[cmd_q.b] <= wr_b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '{op: uet_pkg::OP_NONE, a: '0, b: '0};
			wr_a_q  <= '0;
			wr_b_q  <= '0;
			nz_q    <= '0;
			scan_q  <= '0;
			adj_q   <= 1'b0;
			chg_q   <= 1'b0;
			vert_q  <= '0;
			edge_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					adj_q   <= 1'b0;
					chg_q   <= 1'b0;
					state_q <= S_EMIT;
					case (cmd_q.op)
						uet_pkg::OP_CONNECT: begin
							adj_q <= 1'b1;
							if (!has) begin
								wr_a_q  <= set_a;
								wr_b_q  <= set_b;
								vert_q  <= vert_q + uet_pkg::VCW'(inc);
								edge_q  <= edge_q + uet_pkg::ECW'(1);
								chg_q   <= 1'b1;
								state_q <= S_WR_A;
							end
						end
						uet_pkg::OP_DISCONNECT: begin
							if (has) begin
								wr_a_q  <= clr_a;
								wr_b_q  <= clr_b;
								vert_q  <= vert_q - uet_pkg::VCW'(dec);
								edge_q  <= edge_q - uet_pkg::ECW'(1);
								chg_q   <= 1'b1;
								state_q <= S_WR_A;
							end
						end
						uet_pkg::OP_QUERY: begin
							adj_q <= has;
						end
						uet_pkg::OP_NEIGHBOURS: begin
							scan_q  <= row_a;
							state_q <= S_LIST;
						end
						uet_pkg::OP_EDGES_FROM: begin
							scan_q  <= row_a & ({uet_pkg::MAX_VERTICES{1'b1}} << cmd_q.a);
							state_q <= S_LIST;
						end
						uet_pkg::OP_VERTICES: begin
							scan_q  <= nz_q;
							state_q <= S_LIST;
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				S_WR_A: begin
					nz_q[cmd_q.a] <= (wr_a_q != '0);
					state_q       <= S_WR_B;
				end
				S_WR_B: begin
					nz_q[cmd_q.b] <= (wr_b_q != '0);
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (!res_full) begin
						scan_q <= rest;
						if (rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/uet_outq.sv
module uet_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  uet_pkg::res_t res,
	output logic          res_full,
	input  logic          pop,
	output logic          empty,
	output uet_pkg::res_t head
);

	uet_pkg::res_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_pop;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign head     = slot_q[rd_ptr_q];
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({res_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/undirected_edge_table.sv
// Undirected graph over 64 vertices kept as a symmetric adjacency bit matrix in a
// 64x64 row memory (two read ports, one write port), cleared at reset by one
// nonzero flag per row, so the block is usable right after reset. Requests enter a
// two-deep command queue; the execution unit takes one request at a time and posts
// results into a two-deep result queue. A connect or disconnect that changes the
// table goes through a row read, two row writes (one per endpoint), then the result;
// a query, an unchanged connect/disconnect or an unknown mode skips the writes.
// A list request gives one neighbor or vertex per cycle while the result queue is
// not full, ascending; an empty list gives one result with item_valid low. Counts on
// every result are those after the request.
module undirected_edge_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [2:0]               mode,
	input  logic [uet_pkg::VW-1:0]   vertex_a,
	input  logic [uet_pkg::VW-1:0]   vertex_b,
	output logic                     empty,
	input  logic                     pop,
	output logic                     adjacent,
	output logic                     changed,
	output logic [uet_pkg::VCW-1:0]  vertices_in_use,
	output logic [uet_pkg::ECW-1:0]  edges_in_use,
	output logic [uet_pkg::VW-1:0]   listed_vertex,
	output logic                     item_valid,
	output logic                     last
);

	uet_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_take;
	logic          res_full;
	logic          res_push;
	uet_pkg::res_t res;
	uet_pkg::res_t head;

	uet_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.vertex_a  (vertex_a),
		.vertex_b  (vertex_b),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take)
	);

	uet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	uet_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	assign adjacent        = head.adjacent;
	assign changed         = head.changed;
	assign vertices_in_use = head.vertices_in_use;
	assign edges_in_use    = head.edges_in_use;
	assign listed_vertex   = head.listed_vertex;
	assign item_valid      = head.item_valid;
	assign last            = head.last;

endmodule

### hw/rtl/uet_checker.sv
`include "assert_macros.svh"

module uet_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     empty,
	input logic                     pop,
	input logic [uet_pkg::VCW-1:0]  vertices_in_use,
	input logic [uet_pkg::VW-1:0]   listed_vertex,
	input logic                     item_valid,
	input logic                     last
);

	`UET_ASSERT_IMPL(a_empty_entry_zero, clk, arst_n, !empty && !item_valid, listed_vertex == '0, "result without entry carries a vertex")
	`UET_ASSERT_IMPL(a_nonlast_is_entry, clk, arst_n, !empty && !last, item_valid, "non-final result without list entry")
	`UET_ASSERT(a_vertex_bound, clk, arst_n, empty || (vertices_in_use <= uet_pkg::VCW'(uet_pkg::MAX_VERTICES)), "vertex count above vertex set size")
	`UET_ASSERT_NEXT(a_hold_stalled, clk, arst_n, !empty && !pop, !empty && $stable(listed_vertex) && $stable(last), "stalled result changed")

endmodule

bind undirected_edge_table uet_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.vertices_in_use (vertices_in_use),
	.listed_vertex   (listed_vertex),
	.item_valid      (item_valid),
	.last            (last)
);
